// File: rtl/sfd_pkg.sv
`default_nettype none

package sfd_pkg;

	localparam int BUFFER_BYTES_DEF = 64;

	localparam logic [7:0] SYNC_BYTE     = 8'hAF;
	localparam logic [7:0] START_BYTE    = 8'h02;
	localparam logic [7:0] END_BYTE      = 8'h03;
	// header is node id (2 bytes) and type; payload starts after it
	localparam logic [7:0] PAYLOAD_START = 8'd3;
	localparam logic [7:0] MIN_LEN       = 8'd3;

	typedef enum logic [1:0] {
		PH_SEARCH,
		PH_START,
		PH_LENGTH,
		PH_BODY
	} phase_t;

	// frame handoff from parser to drain unit
	typedef struct packed {
		logic        start;
		logic [7:0]  len;
		logic [15:0] node_id;
		logic [7:0]  msg_type;
	} drain_req_t;

endpackage

`default_nettype wire

// File: rtl/sfd_ram.sv
`default_nettype none

module sfd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64,
	localparam int AW = $clog2(DEPTH)
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// read data holds until the next read
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

// File: rtl/sfd_parser.sv
`default_nettype none

module sfd_parser import sfd_pkg::*; #(
	parameter int BUFFER_BYTES = BUFFER_BYTES_DEF,
	localparam int AW = $clog2(BUFFER_BYTES)
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_fire,
	input  wire logic [7:0]    rx_byte,
	output logic               wr_en,
	output logic      [AW-1:0] wr_addr,
	output logic      [7:0]    wr_data,
	output drain_req_t         req
);

	phase_t      phase_q, phase_d;
	logic [7:0]  slot0_q, slot1_q;
	logic        ptr_q;
	logic [7:0]  len_q;
	logic [7:0]  pos_q;
	logic [15:0] node_q;
	logic [7:0]  type_q;

	logic [7:0]  slot0_new, slot1_new;
	logic        sync_hit;
	logic        body_more;
	logic        in_store;
	logic        len_ok;

	always_comb begin
		slot0_new = ptr_q ? rx_byte : slot0_q;
		slot1_new = ptr_q ? slot1_q : rx_byte;
		sync_hit  = (slot0_new == SYNC_BYTE) && (slot1_new == SYNC_BYTE);
		body_more = pos_q < len_q;
		in_store  = {1'b0, pos_q} < 9'(BUFFER_BYTES);
		len_ok    = (len_q >= MIN_LEN) && ({1'b0, len_q} < 9'(BUFFER_BYTES));
	end

	always_comb begin
		phase_d = phase_q;
		if (in_fire) begin
			case (phase_q)
				PH_SEARCH: if (sync_hit) phase_d = PH_START;
				PH_START:  phase_d = (rx_byte == START_BYTE) ? PH_LENGTH : PH_SEARCH;
				PH_LENGTH: phase_d = PH_BODY;
				PH_BODY:   if (!body_more) phase_d = PH_SEARCH;
				default:   phase_d = PH_SEARCH;
			endcase
		end
	end

	always_comb begin
		wr_en            = in_fire && (phase_q == PH_BODY) && body_more && in_store;
		wr_addr          = pos_q[AW-1:0];
		wr_data          = rx_byte;
		req.start        = in_fire && (phase_q == PH_BODY) && !body_more
			&& (rx_byte == END_BYTE) && len_ok;
		req.len          = len_q;
		req.node_id      = node_q;
		req.msg_type     = type_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_SEARCH;
			slot0_q <= '0;
			slot1_q <= '0;
			ptr_q   <= 1'b0;
			len_q   <= '0;
			pos_q   <= '0;
		end else begin
			phase_q <= phase_d;
			if (in_fire) begin
				case (phase_q)
					PH_SEARCH: begin
						ptr_q <= ~ptr_q;
						if (sync_hit) begin
							slot0_q <= '0;
							slot1_q <= '0;
						end else begin
							slot0_q <= slot0_new;
							slot1_q <= slot1_new;
						end
					end
					PH_LENGTH: begin
						len_q <= rx_byte;
						pos_q <= '0;
					end
					PH_BODY: begin
						if (body_more) pos_q <= pos_q + 8'd1;
					end
					default: ;
				endcase
			end
		end
	end

	// header copies; only read for frames where all three were written
	always_ff @(posedge clk) begin
		if (in_fire && (phase_q == PH_BODY) && body_more) begin
			if (pos_q == 8'd0) node_q[15:8] <= rx_byte;
			if (pos_q == 8'd1) node_q[7:0]  <= rx_byte;
			if (pos_q == 8'd2) type_q       <= rx_byte;
		end
	end

endmodule

`default_nettype wire

// File: rtl/sfd_drain.sv
`default_nettype none

module sfd_drain import sfd_pkg::*; #(
	parameter int BUFFER_BYTES = BUFFER_BYTES_DEF,
	localparam int AW = $clog2(BUFFER_BYTES)
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire drain_req_t    req,
	output logic               busy,
	output logic               rd_en,
	output logic      [AW-1:0] rd_addr,
	input  wire logic [7:0]    rd_data,
	output logic               out_valid,
	input  wire logic          out_ready,
	output logic      [15:0]   out_node_id,
	output logic      [7:0]    out_msg_type,
	output logic      [7:0]    out_data_byte,
	output logic               out_has_byte,
	output logic               out_last
);

	logic        busy_q;
	logic        empty_q;
	logic [7:0]  iss_q;
	logic        iss_last;
	logic        move;

	logic        pend_s1;
	logic        pend_has_s1;
	logic        pend_last_s1;
	logic [15:0] pend_node_s1;
	logic [7:0]  pend_type_s1;

	logic        out_valid_q;
	logic [15:0] out_node_q;
	logic [7:0]  out_type_q;
	logic [7:0]  out_data_q;
	logic        out_has_q;
	logic        out_last_q;

	always_comb begin
		move     = pend_s1 && (!out_valid_q || out_ready);
		rd_en    = busy_q && (!pend_s1 || move);
		rd_addr  = iss_q[AW-1:0];
		iss_last = ({1'b0, iss_q} + 9'd1) >= {1'b0, req.len};
		busy     = busy_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			pend_s1     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (req.start) begin
				busy_q <= 1'b1;
			end else if (rd_en && iss_last) begin
				busy_q <= 1'b0;
			end
			if (rd_en) begin
				pend_s1 <= 1'b1;
			end else if (move) begin
				pend_s1 <= 1'b0;
			end
			if (move) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			iss_q   <= PAYLOAD_START;
			empty_q <= (req.len == MIN_LEN);
		end else if (rd_en) begin
			iss_q <= iss_q + 8'd1;
		end
		if (rd_en) begin
			pend_has_s1  <= !empty_q;
			pend_last_s1 <= iss_last;
			pend_node_s1 <= req.node_id;
			pend_type_s1 <= req.msg_type;
		end
		if (move) begin
			out_node_q <= pend_node_s1;
			out_type_q <= pend_type_s1;
			out_data_q <= pend_has_s1 ? rd_data : 8'd0;
			out_has_q  <= pend_has_s1;
			out_last_q <= pend_last_s1;
		end
	end

	assign out_valid     = out_valid_q;
	assign out_node_id   = out_node_q;
	assign out_msg_type  = out_type_q;
	assign out_data_byte = out_data_q;
	assign out_has_byte  = out_has_q;
	assign out_last      = out_last_q;

	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		req.start |-> !busy_q)
		else $error("frame handed over while drain busy");

	// an empty-payload frame issues its single read at the header length
	a_iss_range: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> (iss_q >= PAYLOAD_START) && ((iss_q < req.len) || (req.len == MIN_LEN)))
		else $error("read address outside payload");

	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		rd_en && iss_last |=> !busy_q)
		else $error("drain still busy after last read");

	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		pend_s1 && !move |-> !rd_en)
		else $error("read issued over pending data");

endmodule

`default_nettype wire

// File: rtl/serial_frame_deframer_core.sv
// Channel  Dir  Signals                     Transaction
// s_       in   tvalid tready tdata[7:0]    one received byte: rx_byte
// m_       out  tvalid tready tdata tuser   one payload result; tlast ends the frame
//              tlast
//
// Cycles: one byte per cycle while hunting, parsing and buffering a frame.
// After a good end byte the input stalls while the frame RAM is read, one
// read per payload byte (a single read for an empty payload); each result
// passes the RAM read register, then the output register, to reach m_.
// Output backpressure stretches the stall.
// Reset: arst_n clears the parser and drain control; the frame RAM is not
// cleared; only entries written in the current frame ever reach the output.
// Stalls: m_tready low holds the output register, then the read stage, then
// read issue; input may still be taken while the last results drain.
`default_nettype none

module serial_frame_deframer_core import sfd_pkg::*; #(
	parameter int BUFFER_BYTES = BUFFER_BYTES_DEF,
	localparam int AW = $clog2(BUFFER_BYTES)
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [7:0]  s_tdata,   // [7:0] rx_byte
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic      [31:0] m_tdata,   // [15:0] node_id, [23:16] msg_type, [31:24] data_byte
	output logic             m_tuser,   // [0] has_byte
	output logic             m_tlast
);

	logic          in_fire;
	logic          wr_en;
	logic [AW-1:0] wr_addr;
	logic [7:0]    wr_data;
	logic          rd_en;
	logic [AW-1:0] rd_addr;
	logic [7:0]    rd_data;
	logic          drain_busy;
	drain_req_t    req;

	logic [15:0]   node_id;
	logic [7:0]    msg_type;
	logic [7:0]    data_byte;

	// input stalls only while a frame's payload is being read out
	assign s_tready = !drain_busy;
	assign in_fire  = s_tvalid && s_tready;

	sfd_parser #(.BUFFER_BYTES(BUFFER_BYTES)) u_parser (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_fire (in_fire),
		.rx_byte (s_tdata),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.req     (req)
	);

	// frame body buffer
	sfd_ram #(.WIDTH(8), .DEPTH(BUFFER_BYTES)) u_ram (
		.clk   (clk),
		.we    (wr_en),
		.waddr (wr_addr),
		.wdata (wr_data),
		.re    (rd_en),
		.raddr (rd_addr),
		.rdata (rd_data)
	);

	sfd_drain #(.BUFFER_BYTES(BUFFER_BYTES)) u_drain (
		.clk           (clk),
		.arst_n        (arst_n),
		.req           (req),
		.busy          (drain_busy),
		.rd_en         (rd_en),
		.rd_addr       (rd_addr),
		.rd_data       (rd_data),
		.out_valid     (m_tvalid),
		.out_ready     (m_tready),
		.out_node_id   (node_id),
		.out_msg_type  (msg_type),
		.out_data_byte (data_byte),
		.out_has_byte  (m_tuser),
		.out_last      (m_tlast)
	);

	assign m_tdata = {data_byte, msg_type, node_id};

endmodule

`default_nettype wire
